[rtl/pllm_pkg.sv]
// shared types and constants of the pooled linked list manager
package pllm_pkg;

    localparam int LINK_W = 7;
    localparam int DATA_W = 32;
    localparam int SLOT_W = 6;
    localparam int REQ_W  = 3;
    localparam int LID_W  = 2;
    localparam int POS_W  = 7;
    localparam int ST_W   = 2;

    localparam logic [LINK_W-1:0] NIL = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_HEAD   = 3'd0,
        REQ_REAR   = 3'd1,
        REQ_POS    = 3'd2,
        REQ_SORTED = 3'd3,
        REQ_READ   = 3'd4
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SEEK,
        S_SORT,
        S_WNODE,
        S_WPREV,
        S_RESULT
    } t_state;

endpackage

[rtl/pllm_if.sv]
// request and response channel interfaces of the pooled linked list manager
interface pllm_req_if;
    logic                          valid;
    logic                          ready;
    logic [pllm_pkg::REQ_W-1:0]    req_type;
    logic [pllm_pkg::LID_W-1:0]    list_id;
    logic signed [pllm_pkg::DATA_W-1:0] value;
    logic [pllm_pkg::POS_W-1:0]    position;

    modport source (output valid, req_type, list_id, value, position, input ready);
    modport sink   (input valid, req_type, list_id, value, position, output ready);
endinterface

interface pllm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pllm_pkg::ST_W-1:0]     status;
    logic signed [pllm_pkg::DATA_W-1:0] data_out;
    logic [pllm_pkg::SLOT_W-1:0]   slot;
    logic                          last;

    modport source (output valid, status, data_out, slot, last, input ready);
    modport sink   (input valid, status, data_out, slot, last, output ready);
endinterface

[rtl/pooled_linked_list_manager_top.sv]
// pooled linked list manager: lists in a shared node pool, walked one memory read a cycle
// head insert, or any insert into an empty list: states WNODE and RESULT in turn
// WPREV follows WNODE when linking after a node; other inserts first walk in SEEK or SORT
// a read gives one word per cycle while the output is not stalled
// one request at a time; a new one is taken while the last result still waits in the output register
// reset clears the list heads, the free pointer and the sequencer; node memories need no clearing
module pooled_linked_list_manager_top #(
    parameter int POOL_SIZE = 64,
    parameter int NUM_LISTS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pllm_req_if.sink          i_req,
    pllm_rsp_if.source        o_rsp
);

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int HW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int LW = pllm_pkg::LINK_W;
    localparam int DW = pllm_pkg::DATA_W;
    localparam int SW = pllm_pkg::SLOT_W;

    // list_id wraps modulo the list count
    function automatic logic [HW-1:0] wrap_lid(input logic [pllm_pkg::LID_W-1:0] id);
        logic [4:0] v;
        v = {3'b000, id};
        for (int i = 0; i < 3; i++) begin
            if (v >= 5'(NUM_LISTS)) begin
                v = v - 5'(NUM_LISTS);
            end
        end
        return v[HW-1:0];
    endfunction

    // node memories
    logic signed [DW-1:0] mem_val  [POOL_SIZE];
    logic [LW-1:0]        mem_link [POOL_SIZE];

    pllm_pkg::t_state     r_state, n_state;
    pllm_pkg::t_req       r_req, n_req;
    logic [HW-1:0]        r_lid, n_lid;
    logic signed [DW-1:0] r_val, n_val;
    logic [pllm_pkg::POS_W-1:0] r_pos, n_pos;
    logic [LW-1:0]        r_cur, n_cur;
    logic [LW-1:0]        r_steps, n_steps;
    logic [LW-1:0]        r_prev, n_prev;
    logic [LW-1:0]        r_nlink, n_nlink;
    // free slots leave in descending order, so the free chain is a down counter
    logic [LW-1:0]        r_free, n_free;
    logic [LW-1:0]        r_heads [NUM_LISTS];

    pllm_pkg::t_status    r_pend_status, n_pend_status;
    logic signed [DW-1:0] r_pend_data, n_pend_data;
    logic [SW-1:0]        r_pend_slot, n_pend_slot;

    logic                 r_o_valid;
    pllm_pkg::t_status    r_o_status;
    logic signed [DW-1:0] r_o_data;
    logic [SW-1:0]        r_o_slot;
    logic                 r_o_last;

    logic signed [DW-1:0] r_q_val;
    logic [LW-1:0]        r_q_link;

    logic                 accept;
    logic [HW-1:0]        in_lid;
    logic [LW-1:0]        in_head;
    logic                 full;
    logic                 out_free;
    logic [LW-1:0]        nx;
    logic                 seek_go;
    logic                 val_less;

    logic [LW-1:0]        rd_addr;
    logic                 node_we;
    logic                 link_we;
    logic [LW-1:0]        link_wa;
    logic [LW-1:0]        link_wd;
    logic                 head_we;
    logic                 out_load;
    pllm_pkg::t_status    out_status;
    logic signed [DW-1:0] out_data;
    logic [SW-1:0]        out_slot;
    logic                 out_last;

    assign accept   = i_req.valid && (r_state == pllm_pkg::S_IDLE);
    assign in_lid   = wrap_lid(i_req.list_id);
    assign in_head  = r_heads[in_lid];
    assign full     = (r_free == pllm_pkg::NIL);
    assign out_free = !r_o_valid || o_rsp.ready;
    assign nx       = (r_q_link < LW'(POOL_SIZE)) ? r_q_link : pllm_pkg::NIL;
    assign seek_go  = (nx != pllm_pkg::NIL)
                   && ((r_req == pllm_pkg::REQ_REAR) || (r_steps < r_pos));
    assign val_less = (r_val < r_q_val);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pllm_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (pllm_pkg::t_req'(i_req.req_type))
                        pllm_pkg::REQ_READ: begin
                            n_state = (in_head == pllm_pkg::NIL) ? pllm_pkg::S_RESULT
                                                                 : pllm_pkg::S_READ;
                        end
                        pllm_pkg::REQ_HEAD, pllm_pkg::REQ_REAR,
                        pllm_pkg::REQ_POS, pllm_pkg::REQ_SORTED: begin
                            priority if (full) begin
                                n_state = pllm_pkg::S_RESULT;
                            end else if (i_req.req_type == pllm_pkg::REQ_HEAD
                                      || in_head == pllm_pkg::NIL
                                      || (i_req.req_type == pllm_pkg::REQ_POS
                                          && i_req.position == '0)) begin
                                n_state = pllm_pkg::S_WNODE;
                            end else if (i_req.req_type == pllm_pkg::REQ_SORTED) begin
                                n_state = pllm_pkg::S_SORT;
                            end else begin
                                n_state = pllm_pkg::S_SEEK;
                            end
                        end
                        default: n_state = pllm_pkg::S_IDLE;
                    endcase
                end
            end
            pllm_pkg::S_READ: begin
                if (out_free && nx == pllm_pkg::NIL) begin
                    n_state = pllm_pkg::S_IDLE;
                end
            end
            pllm_pkg::S_SEEK: begin
                if (!seek_go) begin
                    n_state = pllm_pkg::S_WNODE;
                end
            end
            pllm_pkg::S_SORT: begin
                if (!val_less || nx == pllm_pkg::NIL) begin
                    n_state = pllm_pkg::S_WNODE;
                end
            end
            pllm_pkg::S_WNODE: begin
                n_state = (r_prev == pllm_pkg::NIL) ? pllm_pkg::S_RESULT : pllm_pkg::S_WPREV;
            end
            pllm_pkg::S_WPREV: n_state = pllm_pkg::S_RESULT;
            pllm_pkg::S_RESULT: begin
                if (out_free) begin
                    n_state = pllm_pkg::S_IDLE;
                end
            end
            default: n_state = pllm_pkg::S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_req         = r_req;
        n_lid         = r_lid;
        n_val         = r_val;
        n_pos         = r_pos;
        n_cur         = r_cur;
        n_steps       = r_steps;
        n_prev        = r_prev;
        n_nlink       = r_nlink;
        n_free        = r_free;
        n_pend_status = r_pend_status;
        n_pend_data   = r_pend_data;
        n_pend_slot   = r_pend_slot;
        rd_addr       = r_cur;
        node_we       = 1'b0;
        link_we       = 1'b0;
        link_wa       = r_free;
        link_wd       = r_nlink;
        head_we       = 1'b0;
        out_load      = 1'b0;
        out_status    = r_pend_status;
        out_data      = r_pend_data;
        out_slot      = r_pend_slot;
        out_last      = 1'b1;
        unique case (r_state)
            pllm_pkg::S_IDLE: begin
                rd_addr = in_head;
                if (accept) begin
                    n_req   = pllm_pkg::t_req'(i_req.req_type);
                    n_lid   = in_lid;
                    n_val   = i_req.value;
                    n_pos   = i_req.position;
                    n_cur   = in_head;
                    n_steps = LW'(1);
                    n_prev  = pllm_pkg::NIL;
                    n_nlink = in_head;
                    if (i_req.req_type == pllm_pkg::REQ_READ) begin
                        n_pend_status = pllm_pkg::ST_EMPTY;
                        n_pend_data   = '0;
                    end else begin
                        n_pend_status = pllm_pkg::ST_FULL;
                        n_pend_data   = i_req.value;
                    end
                    n_pend_slot = '0;
                end
            end
            pllm_pkg::S_READ: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = pllm_pkg::ST_OK;
                    out_data   = r_q_val;
                    out_slot   = r_cur[SW-1:0];
                    out_last   = (nx == pllm_pkg::NIL);
                    n_cur      = nx;
                    rd_addr    = nx;
                end
            end
            pllm_pkg::S_SEEK: begin
                if (seek_go) begin
                    n_cur   = nx;
                    n_steps = r_steps + LW'(1);
                    rd_addr = nx;
                end else begin
                    n_prev  = r_cur;
                    n_nlink = nx;
                end
            end
            pllm_pkg::S_SORT: begin
                if (val_less) begin
                    n_prev  = r_cur;
                    n_cur   = nx;
                    n_nlink = nx;
                    rd_addr = nx;
                end else begin
                    // new node goes in front of the current one
                    n_nlink = r_cur;
                end
            end
            pllm_pkg::S_WNODE: begin
                node_we       = 1'b1;
                link_we       = 1'b1;
                head_we       = (r_prev == pllm_pkg::NIL);
                n_free        = (r_free == '0) ? pllm_pkg::NIL : r_free - LW'(1);
                n_pend_status = pllm_pkg::ST_OK;
                n_pend_data   = r_val;
                n_pend_slot   = r_free[SW-1:0];
            end
            pllm_pkg::S_WPREV: begin
                link_we = 1'b1;
                link_wa = r_prev;
                link_wd = {1'b0, r_pend_slot};
            end
            pllm_pkg::S_RESULT: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    // node memories: synchronous write, registered read
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            mem_val[r_free[AW-1:0]] <= r_val;
        end
        if (link_we) begin
            mem_link[link_wa[AW-1:0]] <= link_wd;
        end
        r_q_val  <= mem_val[rd_addr[AW-1:0]];
        r_q_link <= mem_link[rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pllm_pkg::S_IDLE;
            r_free    <= LW'(POOL_SIZE - 1);
            r_o_valid <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_heads[i] <= pllm_pkg::NIL;
            end
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            if (head_we) begin
                r_heads[r_lid] <= r_free;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req         <= n_req;
        r_lid         <= n_lid;
        r_val         <= n_val;
        r_pos         <= n_pos;
        r_cur         <= n_cur;
        r_steps       <= n_steps;
        r_prev        <= n_prev;
        r_nlink       <= n_nlink;
        r_pend_status <= n_pend_status;
        r_pend_data   <= n_pend_data;
        r_pend_slot   <= n_pend_slot;
        if (out_load) begin
            r_o_status <= out_status;
            r_o_data   <= out_data;
            r_o_slot   <= out_slot;
            r_o_last   <= out_last;
        end
    end

    assign i_req.ready    = (r_state == pllm_pkg::S_IDLE);
    assign o_rsp.valid    = r_o_valid;
    assign o_rsp.status   = r_o_status;
    assign o_rsp.data_out = r_o_data;
    assign o_rsp.slot     = r_o_slot;
    assign o_rsp.last     = r_o_last;

endmodule

[rtl/pllm_checker.sv]
// port-level checker of the pooled linked list manager and its bind
module pllm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [pllm_pkg::ST_W-1:0]    i_status,
    input logic [pllm_pkg::DATA_W-1:0]  i_data,
    input logic [pllm_pkg::SLOT_W-1:0]  i_slot,
    input logic                         i_last
);

    // a stalled word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data)
            && $stable(i_status) && $stable(i_slot) && $stable(i_last))
        else $error("response word changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == pllm_pkg::ST_OK || i_status == pllm_pkg::ST_FULL
                      || i_status == pllm_pkg::ST_EMPTY))
        else $error("undefined status code");

    // pool full is a single closing word on slot zero
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == pllm_pkg::ST_FULL |-> i_last && i_slot == '0)
        else $error("pool full word malformed");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == pllm_pkg::ST_EMPTY |-> i_last && i_slot == '0
            && i_data == '0)
        else $error("empty list word malformed");

endmodule

bind pooled_linked_list_manager_top pllm_checker u_pllm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_data      (o_rsp.data_out),
    .i_slot      (o_rsp.slot),
    .i_last      (o_rsp.last)
);

[sim/pooled_linked_list_manager_top_tb.sv]
// self-checking testbench of the pooled linked list manager with a bit-true pool mirror
module pooled_linked_list_manager_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL  = 64;
    localparam int LISTS = 4;
    localparam int N_RANDOM = 360;
    localparam int DRAIN_CYCLES = POOL + 16;

    typedef struct {
        pllm_pkg::t_status           st;
        logic [pllm_pkg::DATA_W-1:0] data;
        logic [pllm_pkg::SLOT_W-1:0] slot;
        logic                        last;
    } t_rsp_word;

    // mirror of the node pool, free list and list heads, plus the words still owed
    class pool_mirror;
        logic [pllm_pkg::DATA_W-1:0] node_vals [POOL];
        logic [pllm_pkg::LINK_W-1:0] node_lnk  [POOL];
        logic [pllm_pkg::LINK_W-1:0] free_ptr;
        logic [pllm_pkg::LINK_W-1:0] heads [LISTS];
        t_rsp_word                   pending_words [$];
        int                          errors;

        function new();
            for (int i = 0; i < POOL; i++) begin
                node_vals[i] = '0;
                node_lnk[i]  = (i == 0) ? pllm_pkg::NIL : pllm_pkg::LINK_W'(i - 1);
            end
            free_ptr = pllm_pkg::LINK_W'(POOL - 1);
            for (int i = 0; i < LISTS; i++) heads[i] = pllm_pkg::NIL;
            errors = 0;
        endfunction

        function logic [pllm_pkg::LINK_W-1:0] next_of(logic [pllm_pkg::LINK_W-1:0] s);
            logic [pllm_pkg::LINK_W-1:0] n;
            n = node_lnk[s];
            return (n < POOL) ? n : pllm_pkg::NIL;
        endfunction

        function void owe(pllm_pkg::t_status st, logic [pllm_pkg::DATA_W-1:0] d,
                          logic [pllm_pkg::LINK_W-1:0] s, logic l);
            t_rsp_word w;
            w.st   = st;
            w.data = d;
            w.slot = s[pllm_pkg::SLOT_W-1:0];
            w.last = l;
            pending_words.push_back(w);
        endfunction

        function void take_request(logic [pllm_pkg::REQ_W-1:0] rq,
                                   logic [pllm_pkg::LID_W-1:0] lid_in,
                                   logic [pllm_pkg::DATA_W-1:0] val,
                                   logic [pllm_pkg::POS_W-1:0] pos);
            int unsigned                 lid;
            int unsigned                 k;
            int unsigned                 steps;
            logic [pllm_pkg::LINK_W-1:0] head;
            logic [pllm_pkg::LINK_W-1:0] prev;
            logic [pllm_pkg::LINK_W-1:0] cur;
            logic [pllm_pkg::LINK_W-1:0] nx;
            logic [pllm_pkg::LINK_W-1:0] node;

            lid  = lid_in % LISTS;
            head = heads[lid];
            prev = pllm_pkg::NIL;
            if (head >= POOL) head = pllm_pkg::NIL;

            if (rq == pllm_pkg::REQ_READ) begin
                if (head == pllm_pkg::NIL) begin
                    owe(pllm_pkg::ST_EMPTY, '0, '0, 1'b1);
                    return;
                end
                cur = head;
                k = 0;
                while (cur != pllm_pkg::NIL && k < POOL) begin
                    nx = next_of(cur);
                    owe(pllm_pkg::ST_OK, node_vals[cur], cur,
                        (nx == pllm_pkg::NIL) || (k == POOL - 1));
                    k++;
                    cur = nx;
                end
                return;
            end
            if (rq > pllm_pkg::REQ_READ) return;

            if (free_ptr >= POOL) begin
                owe(pllm_pkg::ST_FULL, val, '0, 1'b1);
                return;
            end

            // prev stays null when the node goes to the head
            if (rq == pllm_pkg::REQ_REAR || (rq == pllm_pkg::REQ_POS && pos != 0)) begin
                if (head != pllm_pkg::NIL) begin
                    cur = head;
                    steps = 1;
                    while (steps < POOL && next_of(cur) != pllm_pkg::NIL &&
                           (rq == pllm_pkg::REQ_REAR || steps < pos)) begin
                        cur = next_of(cur);
                        steps++;
                    end
                    prev = cur;
                end
            end else if (rq == pllm_pkg::REQ_SORTED) begin
                cur = head;
                steps = 0;
                while (cur != pllm_pkg::NIL && steps < POOL &&
                       $signed(val) < $signed(node_vals[cur])) begin
                    prev = cur;
                    cur = next_of(cur);
                    steps++;
                end
            end

            node = free_ptr;
            free_ptr = next_of(node);
            node_vals[node] = val;
            if (prev == pllm_pkg::NIL) begin
                node_lnk[node] = head;
                heads[lid] = node;
            end else begin
                node_lnk[node] = next_of(prev);
                node_lnk[prev] = node;
            end
            owe(pllm_pkg::ST_OK, val, node, 1'b1);
        endfunction

        function void check_word(logic [pllm_pkg::ST_W-1:0] st,
                                 logic [pllm_pkg::DATA_W-1:0] d,
                                 logic [pllm_pkg::SLOT_W-1:0] s, logic l);
            t_rsp_word w;
            if (pending_words.size() == 0) begin
                $display("%0t: expected no word, actual status %h data %h slot %h last %b",
                         $realtime, st, d, s, l);
                errors++;
                return;
            end
            w = pending_words.pop_front();
            if (st !== w.st) begin
                $display("%0t: status expected %h actual %h", $realtime, w.st, st);
                errors++;
            end
            if (d !== w.data) begin
                $display("%0t: data_out expected %h actual %h", $realtime, w.data, d);
                errors++;
            end
            if (s !== w.slot) begin
                $display("%0t: slot expected %h actual %h", $realtime, w.slot, s);
                errors++;
            end
            if (l !== w.last) begin
                $display("%0t: last expected %b actual %b", $realtime, w.last, l);
                errors++;
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cyc = 0;

    pllm_req_if req_if();
    pllm_rsp_if rsp_if();

    pooled_linked_list_manager_top #(
        .POOL_SIZE(POOL),
        .NUM_LISTS(LISTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    pool_mirror mirror = new();

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) cyc <= cyc + 1;

    // mostly short gaps, a few long ones, none at all in burst stretches
    function automatic int idle_len();
        int r;
        if ((cyc % 1024) < 256) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_word(pllm_pkg::t_req rq, logic [pllm_pkg::LID_W-1:0] lid,
                             logic [pllm_pkg::DATA_W-1:0] val,
                             logic [pllm_pkg::POS_W-1:0] pos);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= rq;
        req_if.list_id  <= lid;
        req_if.value    <= val;
        req_if.position <= pos;
        do @(posedge i_clk); while (!req_if.ready);
        mirror.take_request(rq, lid, val, pos);
    endtask

    task automatic send_random();
        int             r;
        pllm_pkg::t_req rq;
        logic [31:0]    val;
        logic [6:0]     pos;
        r = $urandom_range(0, 99);
        if (r < 35) rq = pllm_pkg::REQ_READ;
        else if (r < 90) rq = pllm_pkg::t_req'($urandom_range(0, 3));
        else rq = pllm_pkg::t_req'($urandom_range(5, 7));
        r = $urandom_range(0, 7);
        if (r < 2) val = 32'($urandom_range(0, 16)) - 32'd8;
        else if (r == 2) val = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
        else val = $urandom;
        r = $urandom_range(0, 2);
        if (r == 0) pos = '0;
        else if (r == 1) pos = 7'($urandom_range(1, 8));
        else pos = 7'($urandom_range(0, 64));
        send_word(rq, 2'($urandom_range(0, 3)), val, pos);
        // ignored codes do not count toward the item total
        if (rq > pllm_pkg::REQ_READ) send_random();
    endtask

    // response side: random back-pressure and one long hold once 150 words have been taken
    initial begin : rsp_side
        int stall_left;
        int seen;
        bit held;
        stall_left = 0;
        seen = 0;
        held = 1'b0;
        rsp_if.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                mirror.check_word(rsp_if.status, rsp_if.data_out, rsp_if.slot, rsp_if.last);
                seen++;
            end
            if (!held && seen >= 150) begin
                held = 1'b1;
                stall_left = 600;
            end
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
                stall_left = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
            end
        end
    end

    initial begin : req_side
        req_if.valid    = 1'b0;
        req_if.req_type = pllm_pkg::REQ_HEAD;
        req_if.list_id  = '0;
        req_if.value    = '0;
        req_if.position = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty read, every insert kind, edge positions and values, ignored codes and a read of each list
        send_word(pllm_pkg::REQ_READ,   2'd0, 32'd0,         7'd0);
        send_word(pllm_pkg::REQ_HEAD,   2'd0, 32'h7fff_ffff, 7'd0);
        send_word(pllm_pkg::REQ_REAR,   2'd0, 32'h8000_0000, 7'd0);
        send_word(pllm_pkg::REQ_REAR,   2'd1, 32'd0,         7'd0);
        send_word(pllm_pkg::REQ_POS,    2'd1, 32'hffff_ffff, 7'd0);
        send_word(pllm_pkg::REQ_POS,    2'd1, 32'd5,         7'd64);
        send_word(pllm_pkg::REQ_POS,    2'd2, 32'd77,        7'd3);
        send_word(pllm_pkg::REQ_POS,    2'd0, 32'd123,       7'd1);
        send_word(pllm_pkg::REQ_SORTED, 2'd3, 32'd10,        7'd0);
        send_word(pllm_pkg::REQ_SORTED, 2'd3, 32'd20,        7'd0);
        send_word(pllm_pkg::REQ_SORTED, 2'd3, 32'd5,         7'd0);
        send_word(pllm_pkg::REQ_SORTED, 2'd3, 32'd10,        7'd127);
        send_word(pllm_pkg::REQ_SORTED, 2'd3, 32'h8000_0000, 7'd0);
        send_word(pllm_pkg::REQ_SORTED, 2'd3, 32'h7fff_ffff, 7'd0);
        send_word(pllm_pkg::t_req'(3'd5), 2'd1, 32'd1,       7'd0);
        send_word(pllm_pkg::t_req'(3'd6), 2'd2, 32'd2,       7'd0);
        send_word(pllm_pkg::t_req'(3'd7), 2'd3, 32'd3,       7'd0);
        for (int l = 0; l < LISTS; l++) send_word(pllm_pkg::REQ_READ, 2'(l), 32'd0, 7'd0);

        for (int n = 0; n < N_RANDOM; n++) send_random();

        // after the pool has filled, more reads so long lists stream out
        for (int l = 0; l < LISTS; l++) begin
            send_word(pllm_pkg::REQ_READ, 2'(l), $urandom, 7'($urandom));
        end
        req_if.valid <= 1'b0;

        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mirror.errors == 0) begin
            $display("pooled_linked_list_manager_top verification clean");
        end else begin
            $display("pooled_linked_list_manager_top verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("pooled_linked_list_manager_top verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/pllm_pkg.sv
rtl/pllm_if.sv
rtl/pooled_linked_list_manager_top.sv
rtl/pllm_checker.sv
sim/pooled_linked_list_manager_top_tb.sv
